// File: hdl/drec_pkg.sv
// shared types and constants for the recent entry cache
package drec_pkg;

	localparam int KEY_W = 256;
	localparam int WORD_W = 64;
	localparam int CAP_W = 7;
	localparam int OCC_W = 7;
	localparam int FLUSH_W = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_NONE = 2'd2;

	typedef struct packed {
		logic action;
		logic [WORD_W-1:0] key_word_3;
		logic [WORD_W-1:0] key_word_2;
		logic [WORD_W-1:0] key_word_1;
		logic [WORD_W-1:0] key_word_0;
		logic [WORD_W-1:0] entry_payload;
		logic [FLUSH_W-1:0] flush_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic was_new;
		logic [WORD_W-1:0] out_key_3;
		logic [WORD_W-1:0] out_key_2;
		logic [WORD_W-1:0] out_key_1;
		logic [WORD_W-1:0] out_key_0;
		logic [WORD_W-1:0] out_payload;
		logic last;
		logic [OCC_W-1:0] occupancy;
	} out_item_t;

endpackage

// File: hdl/dedup_recent_entry_cache_core.sv
// top level of the deduplicating recent entry cache
// add: one key compare per cycle over the held entries, newest first; a miss then writes
//   the entry and loads the reply beat, a hit skips the write and ends the walk early
// flush: each popped entry takes a store read, then a result beat; a flush that pops
//   nothing loads a single empty beat instead; one item at a time, in_ready only
//   while idle and back the cycle after the last beat is loaded, out_ready low holds the walk
// reset: occupancy and newest slot cleared, capacity 64; stores uncleared, only held slots read
module dedup_recent_entry_cache_core #(
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input drec_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output drec_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [drec_pkg::CAP_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > drec_pkg::CAP_W) ? CNT_W : drec_pkg::CAP_W;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_WRITE,
		ST_REPLY,
		ST_EMPTY,
		ST_FL_READ,
		ST_FL_EMIT
	} state_t;

	state_t state_q;

	// control state
	logic [drec_pkg::CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] newest_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] idx_q;
	logic pend_q;
	logic found_q;
	logic [drec_pkg::FLUSH_W-1:0] take_q;

	// held item
	logic [drec_pkg::KEY_W-1:0] key_q;
	logic [drec_pkg::WORD_W-1:0] payload_q;

	// output register
	logic out_valid_q;
	drec_pkg::out_item_t out_q;

	// store port
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [drec_pkg::KEY_W-1:0] rd_key;
	logic [drec_pkg::WORD_W-1:0] rd_payload;

	logic out_free;
	logic beat_load;
	logic search_issue;
	logic key_hit;
	logic [IDX_W-1:0] ptr_dec;
	logic [IDX_W-1:0] newest_inc;
	logic [IDX_W-1:0] newest_dec;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] limit;
	logic [CNT_W-1:0] grown;
	logic [CNT_W-1:0] trimmed;
	logic [drec_pkg::FLUSH_W-1:0] take_c;
	drec_pkg::out_item_t res_d;

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// output register may take a new beat when empty or draining this cycle
	assign out_free = !out_valid_q || out_ready;

	// a result state hands its beat to the output register
	assign beat_load = out_free &&
		((state_q == ST_REPLY) || (state_q == ST_EMPTY) || (state_q == ST_FL_EMIT));

	// ring pointer steps with wrap, valid for any depth
	assign ptr_dec = (rd_ptr_q == '0) ? LAST_SLOT : rd_ptr_q - 1'b1;
	assign newest_inc = (newest_q == LAST_SLOT) ? '0 : newest_q + 1'b1;
	assign newest_dec = (newest_q == '0) ? LAST_SLOT : newest_q - 1'b1;

	// search walk: issue one read per cycle, compare the previous read's key
	assign search_issue = (state_q == ST_SEARCH) && (idx_q < count_q);
	assign key_hit = pend_q && (rd_key == key_q);

	assign rd_en = search_issue || (state_q == ST_FL_READ);
	assign rd_addr = (state_q == ST_FL_READ) ? newest_q : rd_ptr_q;

	// a new entry goes one past the newest, or into the current slot when empty
	assign wr_en = (state_q == ST_WRITE);
	assign wr_addr = (count_q != '0) ? newest_inc : newest_q;

	// capacity above the ring depth acts as the depth
	assign cap_ext = CMP_W'(cap_q);
	assign limit = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;

	// a full ring overwrites its oldest entry, so the count saturates
	assign grown = (count_q < FULL_CNT) ? CNT_W'(count_q + 1'b1) : count_q;
	// oldest entries drop off whenever the count is above the limit after an add
	assign trimmed = (CMP_W'(count_q) > limit) ? CNT_W'(limit) : count_q;

	// entries to pop: the smaller of the request and what is held
	assign take_c = (CMP_W'(in_data.flush_count) < CMP_W'(count_q)) ?
		in_data.flush_count : drec_pkg::FLUSH_W'(count_q);

	// next result beat, by state
	always_comb begin
		res_d = '0;
		res_d.last = 1'b1;
		res_d.occupancy = drec_pkg::OCC_W'(count_q);
		case (state_q)
			ST_REPLY: begin
				res_d.result_kind = drec_pkg::KIND_ADD;
				res_d.was_new = !found_q;
				res_d.occupancy = drec_pkg::OCC_W'(trimmed);
			end
			ST_EMPTY: begin
				res_d.result_kind = drec_pkg::KIND_NONE;
			end
			ST_FL_EMIT: begin
				res_d.result_kind = drec_pkg::KIND_ENTRY;
				res_d.out_key_0 = rd_key[0 +: drec_pkg::WORD_W];
				res_d.out_key_1 = rd_key[drec_pkg::WORD_W +: drec_pkg::WORD_W];
				res_d.out_key_2 = rd_key[2*drec_pkg::WORD_W +: drec_pkg::WORD_W];
				res_d.out_key_3 = rd_key[3*drec_pkg::WORD_W +: drec_pkg::WORD_W];
				res_d.out_payload = rd_payload;
				res_d.last = (take_q == drec_pkg::FLUSH_W'(1));
				res_d.occupancy = drec_pkg::OCC_W'(count_q - 1'b1);
			end
			default: begin
				res_d = '0;
				res_d.last = 1'b1;
				res_d.occupancy = drec_pkg::OCC_W'(count_q);
			end
		endcase
	end

	// sequencer, control state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q <= drec_pkg::CAP_RESET;
			count_q <= '0;
			newest_q <= '0;
			rd_ptr_q <= '0;
			idx_q <= '0;
			pend_q <= 1'b0;
			found_q <= 1'b0;
			take_q <= '0;
			key_q <= '0;
			payload_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			// output register: take the next beat, else drain the held one
			if (beat_load) begin
				out_valid_q <= 1'b1;
				out_q <= res_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q <= {in_data.key_word_3, in_data.key_word_2,
							in_data.key_word_1, in_data.key_word_0};
						payload_q <= in_data.entry_payload;
						if (in_data.action == drec_pkg::ACT_ADD) begin
							rd_ptr_q <= newest_q;
							idx_q <= '0;
							pend_q <= 1'b0;
							state_q <= ST_SEARCH;
						end else if (take_c == '0) begin
							state_q <= ST_EMPTY;
						end else begin
							take_q <= take_c;
							state_q <= ST_FL_READ;
						end
					end
				end
				ST_SEARCH: begin
					if (key_hit) begin
						// key already held: in-flight read is simply dropped
						found_q <= 1'b1;
						pend_q <= 1'b0;
						state_q <= ST_REPLY;
					end else begin
						pend_q <= search_issue;
						if (search_issue) begin
							idx_q <= CNT_W'(idx_q + 1'b1);
							rd_ptr_q <= ptr_dec;
						end else if (!pend_q) begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					newest_q <= wr_addr;
					count_q <= grown;
					found_q <= 1'b0;
					state_q <= ST_REPLY;
				end
				ST_REPLY: begin
					if (out_free) begin
						count_q <= trimmed;
						state_q <= ST_IDLE;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FL_READ: begin
					state_q <= ST_FL_EMIT;
				end
				ST_FL_EMIT: begin
					if (out_free) begin
						count_q <= CNT_W'(count_q - 1'b1);
						newest_q <= newest_dec;
						take_q <= drec_pkg::FLUSH_W'(take_q - 1'b1);
						state_q <= (take_q == drec_pkg::FLUSH_W'(1)) ? ST_IDLE : ST_FL_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	drec_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_key(key_q),
		.wr_payload(payload_q),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_key(rd_key),
		.rd_payload(rd_payload)
	);

	// occupancy never exceeds the ring depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("occupancy above ring depth");

	// the search walk never reads past the held entries
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (idx_q <= count_q))
		else $error("search walk beyond held entries");

	// occupancy is frozen while the keys are being compared
	a_search_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |=> $stable(count_q))
		else $error("occupancy changed during search");

	// every pop has an entry behind it
	a_pop_backed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FL_READ) |->
			(take_q != '0) && (CMP_W'(take_q) <= CMP_W'(count_q)))
		else $error("pop without a held entry");

endmodule

// File: hdl/drec_store.sv
// ring storage for entry keys and payloads, one write and one registered read port
module drec_store #(
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [drec_pkg::KEY_W-1:0] wr_key,
	input logic [drec_pkg::WORD_W-1:0] wr_payload,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [drec_pkg::KEY_W-1:0] rd_key,
	output logic [drec_pkg::WORD_W-1:0] rd_payload
);

	logic [drec_pkg::KEY_W-1:0] key_mem [DEPTH];
	logic [drec_pkg::WORD_W-1:0] payload_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			payload_mem[wr_addr] <= wr_payload;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key <= key_mem[rd_addr];
			rd_payload <= payload_mem[rd_addr];
		end
	end

endmodule

// File: sim/tb_dedup_recent_entry_cache_core.sv
// self-checking testbench for the deduplicating recent entry cache core
`timescale 1ns / 1ps

module tb_dedup_recent_entry_cache_core;

	localparam int DEPTH = 64;
	localparam int KEY_POOL_SIZE = 24;
	localparam int HOLD_CYCLES = 400;
	localparam logic [drec_pkg::KEY_W-1:0] ALL_ONES_KEY = '1;
	localparam logic [drec_pkg::KEY_W-1:0] LOW_WORD_MASK =
		{{(drec_pkg::KEY_W-drec_pkg::WORD_W){1'b0}}, {drec_pkg::WORD_W{1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	drec_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	drec_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [drec_pkg::CAP_W-1:0] cfg_data = '0;

	// stimulus and scoreboard
	drec_pkg::in_item_t queued_requests[$];
	drec_pkg::out_item_t awaited_beats[$];
	logic [drec_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];
	int mismatches = 0;

	// mirror of the cache contents: ring of slots, newest slot and fill level
	logic [drec_pkg::KEY_W-1:0] ring_key [DEPTH];
	logic [drec_pkg::WORD_W-1:0] ring_payload [DEPTH];
	int ring_top = 0;
	int ring_fill = 0;
	int cap_shadow = 64;

	// pacing controls, set per phase
	logic tx_steady = 1'b0;
	logic rx_steady = 1'b0;
	logic hold_arm = 1'b0;
	logic hold_done;
	int hold_count;
	int tx_wait;
	int rx_wait;

	dedup_recent_entry_cache_core #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int draw_wait(input logic steady);
		return steady ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic [drec_pkg::KEY_W-1:0] random_key();
		return {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
	endfunction

	// expected beats for one accepted request; updates the mirror as the cache would
	task automatic predict_cache_beats(input drec_pkg::in_item_t req);
		logic [drec_pkg::KEY_W-1:0] key;
		drec_pkg::out_item_t beat;
		logic hit;
		int take;
		int lim;
		int slot;
		key = {req.key_word_3, req.key_word_2, req.key_word_1, req.key_word_0};
		beat = '0;
		if (req.action == drec_pkg::ACT_ADD) begin
			// search newest to oldest over the held entries only
			hit = 1'b0;
			for (int i = 0; i < ring_fill; i++) begin
				if (ring_key[(ring_top + DEPTH - i) % DEPTH] == key) begin
					hit = 1'b1;
					break;
				end
			end
			if (!hit) begin
				// an empty ring reuses the current slot, otherwise step forward;
				// a full ring thereby overwrites its oldest entry
				if (ring_fill > 0)
					ring_top = (ring_top + 1) % DEPTH;
				ring_key[ring_top] = key;
				ring_payload[ring_top] = req.entry_payload;
				if (ring_fill < DEPTH)
					ring_fill++;
			end
			// capacity above the ring size behaves as the ring size
			lim = (cap_shadow > DEPTH) ? DEPTH : cap_shadow;
			if (ring_fill > lim)
				ring_fill = lim;
			beat.result_kind = drec_pkg::KIND_ADD;
			beat.was_new = !hit;
			beat.last = 1'b1;
			beat.occupancy = drec_pkg::OCC_W'(ring_fill);
			awaited_beats.push_back(beat);
		end else begin
			take = (int'(req.flush_count) < ring_fill) ? int'(req.flush_count) : ring_fill;
			if (take == 0) begin
				beat.result_kind = drec_pkg::KIND_NONE;
				beat.last = 1'b1;
				beat.occupancy = drec_pkg::OCC_W'(ring_fill);
				awaited_beats.push_back(beat);
			end else begin
				// pop from the newest end, one beat per entry
				for (int i = 0; i < take; i++) begin
					slot = ring_top;
					ring_fill--;
					ring_top = (ring_top + DEPTH - 1) % DEPTH;
					beat = '0;
					beat.result_kind = drec_pkg::KIND_ENTRY;
					beat.out_key_0 = ring_key[slot][drec_pkg::WORD_W-1:0];
					beat.out_key_1 = ring_key[slot][2*drec_pkg::WORD_W-1:drec_pkg::WORD_W];
					beat.out_key_2 =
						ring_key[slot][3*drec_pkg::WORD_W-1:2*drec_pkg::WORD_W];
					beat.out_key_3 =
						ring_key[slot][4*drec_pkg::WORD_W-1:3*drec_pkg::WORD_W];
					beat.out_payload = ring_payload[slot];
					beat.last = (i == take - 1);
					beat.occupancy = drec_pkg::OCC_W'(ring_fill);
					awaited_beats.push_back(beat);
				end
			end
		end
	endtask

	task automatic note_field(input string name, input logic [drec_pkg::WORD_W-1:0] want,
		input logic [drec_pkg::WORD_W-1:0] got, inout logic bad);
		if (got !== want) begin
			if (mismatches < 10)
				$display("mismatch in %s: expected %h, got %h", name, want, got);
			bad = 1'b1;
		end
	endtask

	task automatic compare_beat(input drec_pkg::out_item_t want,
		input drec_pkg::out_item_t got);
		logic bad;
		bad = 1'b0;
		note_field("result_kind", drec_pkg::WORD_W'(want.result_kind),
			drec_pkg::WORD_W'(got.result_kind), bad);
		note_field("was_new", drec_pkg::WORD_W'(want.was_new),
			drec_pkg::WORD_W'(got.was_new), bad);
		note_field("out_key_0", want.out_key_0, got.out_key_0, bad);
		note_field("out_key_1", want.out_key_1, got.out_key_1, bad);
		note_field("out_key_2", want.out_key_2, got.out_key_2, bad);
		note_field("out_key_3", want.out_key_3, got.out_key_3, bad);
		note_field("out_payload", want.out_payload, got.out_payload, bad);
		note_field("last", drec_pkg::WORD_W'(want.last), drec_pkg::WORD_W'(got.last), bad);
		note_field("occupancy", drec_pkg::WORD_W'(want.occupancy),
			drec_pkg::WORD_W'(got.occupancy), bad);
		if (bad)
			mismatches++;
	endtask

	function automatic drec_pkg::in_item_t add_request(
		input logic [drec_pkg::KEY_W-1:0] key,
		input logic [drec_pkg::WORD_W-1:0] payload);
		drec_pkg::in_item_t r;
		r = '0;
		r.action = drec_pkg::ACT_ADD;
		{r.key_word_3, r.key_word_2, r.key_word_1, r.key_word_0} = key;
		r.entry_payload = payload;
		r.flush_count = drec_pkg::FLUSH_W'($urandom);
		return r;
	endfunction

	function automatic drec_pkg::in_item_t flush_request(input int count);
		drec_pkg::in_item_t r;
		r = add_request(random_key(), {$urandom, $urandom});
		r.action = drec_pkg::ACT_FLUSH;
		r.flush_count = drec_pkg::FLUSH_W'(count);
		return r;
	endfunction

	function automatic drec_pkg::in_item_t random_request(input int add_pct,
		input int fresh_pct);
		drec_pkg::in_item_t r;
		logic [drec_pkg::KEY_W-1:0] key;
		int pick;
		if ($urandom_range(0, 99) < fresh_pct)
			key = random_key();
		else
			key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
		r = add_request(key, {$urandom, $urandom});
		if ($urandom_range(0, 99) >= add_pct)
			r.action = drec_pkg::ACT_FLUSH;
		// mostly short flushes, now and then the whole range
		pick = $urandom_range(0, 9);
		if (pick < 6)
			r.flush_count = drec_pkg::FLUSH_W'($urandom_range(0, 6));
		else if (pick < 8)
			r.flush_count = drec_pkg::FLUSH_W'($urandom_range(0, 127));
		else if (pick == 8)
			r.flush_count = drec_pkg::FLUSH_W'(DEPTH);
		else
			r.flush_count = '1;
		return r;
	endfunction

	// sender: one request per beat, a random pause after each unless pacing is steady
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			tx_wait <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_cache_beats(in_data);
			if (!in_valid || in_ready) begin
				if (tx_wait > 0) begin
					in_valid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (queued_requests.size() != 0) begin
					in_data <= queued_requests[0];
					queued_requests.delete(0);
					in_valid <= 1'b1;
					tx_wait <= draw_wait(tx_steady);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here and seen by the receiver below
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count <= 0;
			hold_done <= 1'b0;
		end else if (hold_arm && !hold_done) begin
			if (hold_count == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
			hold_count <= hold_count + 1;
		end
	end

	// receiver: checks each beat against the oldest awaited one
	always @(posedge clk or negedge arst_n) begin : receiver
		int next_wait;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_beats.size() == 0) begin
					if (mismatches < 10)
						$display("beat with nothing awaited: kind %0d occupancy %0d",
							out_data.result_kind, out_data.occupancy);
					mismatches++;
				end else begin
					compare_beat(awaited_beats[0], out_data);
					awaited_beats.delete(0);
				end
				next_wait = draw_wait(rx_steady);
			end else begin
				next_wait = (rx_wait > 0) ? rx_wait - 1 : 0;
			end
			rx_wait <= next_wait;
			out_ready <= (next_wait == 0) && !(hold_arm && !hold_done);
		end
	end

	// stimulus waits until every queued request is sent, every awaited beat is in and the block is quiet
	task automatic wait_drained();
		do
			@(negedge clk);
		while (queued_requests.size() != 0 || in_valid || awaited_beats.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [drec_pkg::CAP_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cap_shadow = int'(value);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [drec_pkg::CAP_W-1:0] cap, input int count,
		input int add_pct, input int fresh_pct, input logic tx_s, input logic rx_s,
		input logic press);
		wait_drained();
		set_capacity(cap);
		@(posedge clk);
		tx_steady <= tx_s;
		rx_steady <= rx_s;
		if (press)
			hold_arm <= 1'b1;
		@(negedge clk);
		repeat (count)
			queued_requests.push_back(random_request(add_pct, fresh_pct));
	endtask

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		logic [drec_pkg::KEY_W-1:0] spare [5];
		int w;
		// key pool with near twins: every fourth key differs from its neighbour in one word
		for (int i = 0; i < KEY_POOL_SIZE; i++) begin
			key_pool[i] = random_key();
			if (i % 4 == 3) begin
				w = $urandom_range(0, 3);
				key_pool[i] = key_pool[i - 1];
				key_pool[i][drec_pkg::WORD_W*w +: drec_pkg::WORD_W] =
					~key_pool[i - 1][drec_pkg::WORD_W*w +: drec_pkg::WORD_W];
			end
		end
		for (int i = 0; i < 5; i++)
			spare[i] = random_key();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty flushes, extreme keys and payloads, a duplicate, keys one word apart
		queued_requests.push_back(flush_request(0));
		queued_requests.push_back(flush_request(5));
		queued_requests.push_back(add_request('0, '0));
		queued_requests.push_back(add_request(ALL_ONES_KEY, '1));
		queued_requests.push_back(add_request(ALL_ONES_KEY, 64'd5));
		for (int i = 0; i < 4; i++)
			queued_requests.push_back(add_request(
				ALL_ONES_KEY ^ (LOW_WORD_MASK << (drec_pkg::WORD_W*i)),
				{$urandom, $urandom}));
		// oldest entry still found
		queued_requests.push_back(add_request('0, '1));
		queued_requests.push_back(flush_request(0));
		queued_requests.push_back(flush_request(2));
		queued_requests.push_back(flush_request(127));

		// zero capacity: reported as new but never kept
		wait_drained();
		set_capacity('0);
		@(negedge clk);
		queued_requests.push_back(add_request(spare[0], {$urandom, $urandom}));
		queued_requests.push_back(add_request(spare[0], {$urandom, $urandom}));
		queued_requests.push_back(flush_request(3));

		// fill to five, then lower the capacity: a flush leaves it untrimmed,
		// the next add trims it and the dropped oldest key comes back as new
		wait_drained();
		set_capacity(drec_pkg::CAP_W'(5));
		@(negedge clk);
		for (int i = 0; i < 5; i++)
			queued_requests.push_back(add_request(spare[i], {$urandom, $urandom}));
		wait_drained();
		set_capacity(drec_pkg::CAP_W'(2));
		@(negedge clk);
		queued_requests.push_back(flush_request(1));
		queued_requests.push_back(add_request(random_key(), {$urandom, $urandom}));
		queued_requests.push_back(add_request(spare[0], {$urandom, $urandom}));

		// random phases; the first wraps the ring with mostly fresh keys
		run_phase('1, 90, 95, 90, 1'b0, 1'b0, 1'b0);
		run_phase(drec_pkg::CAP_W'(DEPTH), 60, 70, 40, 1'b0, 1'b0, 1'b0);
		run_phase(drec_pkg::CAP_W'(DEPTH + 1), 60, 65, 30, 1'b1, 1'b1, 1'b0);
		// receiver holds off while the sender keeps offering
		run_phase(drec_pkg::CAP_W'(DEPTH), 50, 60, 40, 1'b1, 1'b0, 1'b1);
		run_phase(drec_pkg::CAP_W'(1), 40, 70, 30, 1'b0, 1'b0, 1'b0);
		run_phase('0, 30, 70, 30, 1'b0, 1'b1, 1'b0);
		run_phase(drec_pkg::CAP_W'($urandom_range(2, DEPTH - 1)), 60, 70, 40,
			1'b0, 1'b0, 1'b0);
		run_phase(drec_pkg::CAP_W'(8), 40, 70, 50, 1'b0, 1'b0, 1'b0);
		run_phase(drec_pkg::CAP_W'(DEPTH), 50, 50, 40, 1'b0, 1'b0, 1'b0);

		wait_drained();
		// room for any stray beat after the last one awaited
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: dedup_recent_entry_cache_core.f
hdl/drec_pkg.sv
hdl/drec_store.sv
hdl/dedup_recent_entry_cache_core.sv
sim/tb_dedup_recent_entry_cache_core.sv
